// ----- design/tepb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile-edge alpha pixel blend: shared package
// Payload types, blend mode codes and tile constants for the blend core.
// ----------------------------------------------------------------------------
package tepb_pkg;

    // Largest tile edge in pixels; a larger tile side is clamped to this.
    localparam int TILE_MAX = 128;

    localparam int SAMPLE_W = 8;
    localparam int POS_W    = 7;
    localparam int SIDE_W   = 8;
    localparam int MODE_W   = 3;

    localparam logic [MODE_W-1:0] MODE_NORMAL     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DIFFERENCE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MULTIPLY   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LUMA_ONLY  = 3'd4;

    // Edge ramp values, indexed by distance from a tile edge.
    localparam logic [SAMPLE_W-1:0] RAMP_EDGE0  = 8'd85;
    localparam logic [SAMPLE_W-1:0] RAMP_EDGE1  = 8'd141;
    localparam logic [SAMPLE_W-1:0] RAMP_EDGE2  = 8'd197;
    localparam logic [SAMPLE_W-1:0] RAMP_OPAQUE = 8'd255;

    typedef struct packed {
        logic [SAMPLE_W-1:0] dest_luma;
        logic [SAMPLE_W-1:0] dest_cb;
        logic [SAMPLE_W-1:0] dest_cr;
        logic [SAMPLE_W-1:0] source_luma;
        logic [SAMPLE_W-1:0] source_cb;
        logic [SAMPLE_W-1:0] source_cr;
        logic [POS_W-1:0]    column_in_tile;
        logic [POS_W-1:0]    row_in_tile;
        logic [SIDE_W-1:0]   tile_side;
    } pix_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] result_luma;
        logic [SAMPLE_W-1:0] result_cb;
        logic [SAMPLE_W-1:0] result_cr;
    } pix_res_t;

endpackage

// ----- design/tepb_pix_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile-edge alpha pixel blend: pixel pair channel
// Valid/ready channel carrying one destination and source pixel with position.
// ----------------------------------------------------------------------------
interface tepb_pix_if;
    import tepb_pkg::*;

    logic     valid;
    logic     ready;
    pix_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/tepb_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile-edge alpha pixel blend: composited pixel channel
// Valid/ready channel carrying one composited YUV pixel.
// ----------------------------------------------------------------------------
interface tepb_res_if;
    import tepb_pkg::*;

    logic     valid;
    logic     ready;
    pix_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/tile_edge_alpha_pixel_blend_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile-edge alpha pixel blend core
// Composites a source YUV pixel onto a destination pixel with an alpha taken
// from the pixel's position in a square tile, under one of five blend modes.
// ----------------------------------------------------------------------------
//   Channel      Kind         Carries
//   pixels       valid/ready  destination and source pixel, column, row, side
//   composite    valid/ready  composited Y, U and V samples
//   mode_we      write strobe blend mode register, data on mode_wdata
//
// A pixel pair is taken every clock while the pipeline has room; it passes
// through the four register stages in order: ramps, alpha, products, sums.
// Reset clears every stage's valid bit and sets the blend mode to normal.
// A stall on the composite side holds the last stage; earlier stages keep
// moving until they fill, so bubbles are squeezed out and nothing is lost.
// ----------------------------------------------------------------------------
module tile_edge_alpha_pixel_blend_core (
    input  logic                           clk,
    input  logic                           rst_n,
    tepb_pix_if.sink                       pixels,
    tepb_res_if.source                     composite,
    input  logic                           mode_we,
    input  logic [tepb_pkg::MODE_W-1:0]    mode_wdata
);
    import tepb_pkg::*;

    // Clamped tile side, ramp index and ramp value helpers.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] side);
        logic [SIDE_W:0] side_w;
        side_w = {1'b0, side};
        if (side_w > (SIDE_W+1)'(TILE_MAX))
            clamp_side = SIDE_W'(TILE_MAX);
        else
            clamp_side = side;
    endfunction

    function automatic logic [SAMPLE_W-1:0] edge_ramp(input logic [POS_W-1:0]  pos,
                                                       input logic [SIDE_W-1:0] side);
        logic [SIDE_W:0] pos_w;
        logic [SIDE_W:0] side_w;
        logic [SIDE_W:0] tail_dist;
        logic [1:0]      idx;
        pos_w     = {{(SIDE_W+1-POS_W){1'b0}}, pos};
        side_w    = {1'b0, side};
        tail_dist = side_w - pos_w - (SIDE_W+1)'(1);
        if (pos_w < (SIDE_W+1)'(3))
            idx = pos[1:0];
        else if ((pos_w < side_w) && (pos_w + (SIDE_W+1)'(3) >= side_w))
            idx = tail_dist[1:0];
        else
            idx = 2'd3;
        case (idx)
            2'd0:    edge_ramp = RAMP_EDGE0;
            2'd1:    edge_ramp = RAMP_EDGE1;
            2'd2:    edge_ramp = RAMP_EDGE2;
            default: edge_ramp = RAMP_OPAQUE;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] round_mix(input logic [15:0] x);
        round_mix = SAMPLE_W'((x + 16'd1 + (x >> 8)) >> 8);
    endfunction

    logic [MODE_W-1:0] blend_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blend_mode_reg <= MODE_NORMAL;
        else if (mode_we)
            blend_mode_reg <= mode_wdata;
    end

    // Valid bits and stage advance chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !v4_reg || composite.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign pixels.ready    = adv1;
    assign composite.valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= pixels.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // Stage 1: per-axis edge ramps.
    logic [SAMPLE_W-1:0] s1_dy_reg, s1_du_reg, s1_dv_reg;
    logic [SAMPLE_W-1:0] s1_sy_reg, s1_su_reg, s1_sv_reg;
    logic [SAMPLE_W-1:0] ramp_x_reg, ramp_y_reg;
    logic [SIDE_W-1:0]   side_c;

    assign side_c = clamp_side(pixels.data.tile_side);

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_dy_reg  <= pixels.data.dest_luma;
            s1_du_reg  <= pixels.data.dest_cb;
            s1_dv_reg  <= pixels.data.dest_cr;
            s1_sy_reg  <= pixels.data.source_luma;
            s1_su_reg  <= pixels.data.source_cb;
            s1_sv_reg  <= pixels.data.source_cr;
            ramp_x_reg <= edge_ramp(pixels.data.column_in_tile, side_c);
            ramp_y_reg <= edge_ramp(pixels.data.row_in_tile, side_c);
        end
    end

    // Stage 2: alpha from the product of the two ramps.
    logic [SAMPLE_W-1:0] s2_dy_reg, s2_du_reg, s2_dv_reg;
    logic [SAMPLE_W-1:0] s2_sy_reg, s2_su_reg, s2_sv_reg;
    logic [SAMPLE_W-1:0] alpha_reg;
    logic [15:0]         ramp_prod;

    assign ramp_prod = 16'(ramp_x_reg) * 16'(ramp_y_reg);

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_dy_reg <= s1_dy_reg;
            s2_du_reg <= s1_du_reg;
            s2_dv_reg <= s1_dv_reg;
            s2_sy_reg <= s1_sy_reg;
            s2_su_reg <= s1_su_reg;
            s2_sv_reg <= s1_sv_reg;
            alpha_reg <= ramp_prod[15:8];
        end
    end

    // Stage 3: weighted products for every plane, plus the luma-only terms.
    logic [SAMPLE_W-1:0] inv_alpha;
    logic [15:0]         pd_y_reg, ps_y_reg, pd_u_reg, ps_u_reg, pd_v_reg, ps_v_reg;
    logic [15:0]         pm_y_reg;
    logic [SAMPLE_W-1:0] s3_dy_reg, s3_du_reg, s3_dv_reg, absdiff_reg;

    assign inv_alpha = RAMP_OPAQUE - alpha_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            pd_y_reg    <= 16'(s2_dy_reg) * 16'(inv_alpha);
            ps_y_reg    <= 16'(s2_sy_reg) * 16'(alpha_reg);
            pd_u_reg    <= 16'(s2_du_reg) * 16'(inv_alpha);
            ps_u_reg    <= 16'(s2_su_reg) * 16'(alpha_reg);
            pd_v_reg    <= 16'(s2_dv_reg) * 16'(inv_alpha);
            ps_v_reg    <= 16'(s2_sv_reg) * 16'(alpha_reg);
            pm_y_reg    <= 16'(s2_dy_reg) * 16'(s2_sy_reg);
            absdiff_reg <= (s2_dy_reg >= s2_sy_reg) ? (s2_dy_reg - s2_sy_reg)
                                                    : (s2_sy_reg - s2_dy_reg);
            s3_dy_reg   <= s2_dy_reg;
            s3_du_reg   <= s2_du_reg;
            s3_dv_reg   <= s2_dv_reg;
        end
    end

    // Stage 4: rounding sums and mode selection into the output register.
    logic [SAMPLE_W-1:0] mix_y, mix_u, mix_v, add_y, mul_y;
    logic [SAMPLE_W:0]   add_sum;
    logic [15:0]         mul_round;
    pix_res_t            res_next;
    pix_res_t            res_reg;

    assign mix_y     = round_mix(pd_y_reg + ps_y_reg);
    assign mix_u     = round_mix(pd_u_reg + ps_u_reg);
    assign mix_v     = round_mix(pd_v_reg + ps_v_reg);
    assign add_sum   = {1'b0, s3_dy_reg} + {1'b0, ps_y_reg[15:8]};
    assign add_y     = add_sum[SAMPLE_W] ? RAMP_OPAQUE : add_sum[SAMPLE_W-1:0];
    assign mul_round = pm_y_reg + 16'd128;
    assign mul_y     = mul_round[15:8];

    always_comb
    begin
        res_next.result_cb = s3_du_reg;
        res_next.result_cr = s3_dv_reg;
        case (blend_mode_reg)
            MODE_ADD:
            begin
                res_next.result_luma = add_y;
                res_next.result_cb   = mix_u;
                res_next.result_cr   = mix_v;
            end
            MODE_DIFFERENCE: res_next.result_luma = absdiff_reg;
            MODE_MULTIPLY:   res_next.result_luma = mul_y;
            MODE_LUMA_ONLY:  res_next.result_luma = mix_y;
            default:
            begin
                // Normal blend, also taken by the unused mode codes.
                res_next.result_luma = mix_y;
                res_next.result_cb   = mix_u;
                res_next.result_cr   = mix_v;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
            res_reg <= res_next;
    end

    assign composite.data = res_reg;

    // The input side only stalls when every stage is holding an item.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with a free pipeline stage");

    // An item moving out of stage one arrives in stage two.
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv2) |=> v2_reg)
        else $error("item lost between ramp and alpha stages");

    // Ramp registers only ever hold one of the four ramp levels.
    a_ramp_level: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ((ramp_x_reg == RAMP_EDGE0 || ramp_x_reg == RAMP_EDGE1 ||
                     ramp_x_reg == RAMP_EDGE2 || ramp_x_reg == RAMP_OPAQUE) &&
                    (ramp_y_reg == RAMP_EDGE0 || ramp_y_reg == RAMP_EDGE1 ||
                     ramp_y_reg == RAMP_EDGE2 || ramp_y_reg == RAMP_OPAQUE)))
        else $error("edge ramp outside its levels");

    // Alpha is at most 254, so the destination weight is never zero.
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (alpha_reg != RAMP_OPAQUE))
        else $error("alpha reached full scale");

endmodule

// ----- sim/tepb_blend_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile-edge alpha pixel blend: composite checker
// Watches the pixel and composite channels and the blend mode strobe. It
// predicts each composite from the accepted pixel pair and compares the
// composites in order, counting every mismatch and every stray composite.
// ----------------------------------------------------------------------------
module tepb_blend_checker
    import tepb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tepb_pix_if               pixels,
    tepb_res_if               composite,
    input  logic              mode_we,
    input  logic [MODE_W-1:0] mode_wdata,
    output int                mismatches,
    output int                outstanding,
    output int                composites_checked
);

    localparam int RAMP_STEP = 56;

    logic [MODE_W-1:0] blend_mode_copy;
    pix_res_t          expected_composites[$];

    // Opacity along one axis: the leading edge rule takes precedence over the
    // trailing one, and anything outside both zones is fully opaque.
    function automatic logic [SAMPLE_W-1:0] axis_ramp(input logic [POS_W-1:0] pos,
                                                      input logic [SIDE_W-1:0] side);
        int unsigned p;
        int unsigned n;
        p = pos;
        n = side;
        if (p < 3)
            return SAMPLE_W'(RAMP_EDGE0 + RAMP_STEP * p);
        if (p < n && p + 3 >= n)
            return SAMPLE_W'(RAMP_EDGE0 + RAMP_STEP * (n - 1 - p));
        return RAMP_OPAQUE;
    endfunction

    function automatic logic [SAMPLE_W-1:0] mix_sample(input logic [SAMPLE_W-1:0] d,
                                                       input logic [SAMPLE_W-1:0] s,
                                                       input logic [SAMPLE_W-1:0] a);
        int unsigned weighted;
        weighted = d * (255 - a) + s * a;
        return SAMPLE_W'(((weighted + 1) + (weighted >> 8)) >> 8);
    endfunction

    function automatic pix_res_t predict_composite(input pix_req_t req,
                                                   input logic [MODE_W-1:0] mode);
        pix_res_t          res;
        logic [SIDE_W-1:0] side;
        logic [SAMPLE_W-1:0] alpha;
        int unsigned       ramp_col;
        int unsigned       ramp_row;
        int unsigned       dy;
        int unsigned       sy;
        int unsigned       sum;
        side     = (req.tile_side > TILE_MAX) ? SIDE_W'(TILE_MAX) : req.tile_side;
        ramp_col = axis_ramp(req.column_in_tile, side);
        ramp_row = axis_ramp(req.row_in_tile, side);
        alpha    = SAMPLE_W'((ramp_col * ramp_row) >> 8);
        dy = req.dest_luma;
        sy = req.source_luma;
        res.result_cb = req.dest_cb;
        res.result_cr = req.dest_cr;
        case (mode)
            MODE_ADD:
            begin
                sum = dy + ((sy * alpha) >> 8);
                res.result_luma = (sum > 255) ? 8'hFF : SAMPLE_W'(sum);
                res.result_cb   = mix_sample(req.dest_cb, req.source_cb, alpha);
                res.result_cr   = mix_sample(req.dest_cr, req.source_cr, alpha);
            end
            MODE_DIFFERENCE:
                res.result_luma = SAMPLE_W'((dy >= sy) ? dy - sy : sy - dy);
            MODE_MULTIPLY:
                res.result_luma = SAMPLE_W'((dy * sy + 128) >> 8);
            MODE_LUMA_ONLY:
                res.result_luma = mix_sample(req.dest_luma, req.source_luma, alpha);
            default:
            begin
                // Normal mode, and the spare codes that fall back to it.
                res.result_luma = mix_sample(req.dest_luma, req.source_luma, alpha);
                res.result_cb   = mix_sample(req.dest_cb, req.source_cb, alpha);
                res.result_cr   = mix_sample(req.dest_cr, req.source_cr, alpha);
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pix_res_t want;
        pix_res_t got;
        if (!rst_n)
        begin
            blend_mode_copy = MODE_NORMAL;
        end
        else
        begin
            if (pixels.valid === 1'b1 && pixels.ready === 1'b1)
                expected_composites.push_back(predict_composite(pixels.data,
                                                                blend_mode_copy));
            if (composite.valid === 1'b1 && composite.ready === 1'b1)
            begin
                got = composite.data;
                if (expected_composites.size() == 0)
                begin
                    $error("composite transfer with no pixel pair outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_composites.pop_front();
                    composites_checked++;
                    if (got.result_luma !== want.result_luma)
                    begin
                        $error("result_luma: expected %0d, actual %0d",
                               want.result_luma, got.result_luma);
                        mismatches++;
                    end
                    if (got.result_cb !== want.result_cb)
                    begin
                        $error("result_cb: expected %0d, actual %0d",
                               want.result_cb, got.result_cb);
                        mismatches++;
                    end
                    if (got.result_cr !== want.result_cr)
                    begin
                        $error("result_cr: expected %0d, actual %0d",
                               want.result_cr, got.result_cr);
                        mismatches++;
                    end
                end
            end
            if (mode_we === 1'b1)
                blend_mode_copy = mode_wdata;
        end
        outstanding = expected_composites.size();
    end

    initial
    begin
        mismatches         = 0;
        outstanding        = 0;
        composites_checked = 0;
        blend_mode_copy    = MODE_NORMAL;
    end

endmodule

// ----- sim/tb_tile_edge_alpha_pixel_blend_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile-edge alpha pixel blend core: testbench top
// Drives directed and random pixel pairs through every blend code, with
// random gaps on the pixel side and random stalls on the composite side,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_tile_edge_alpha_pixel_blend_core;
    import tepb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
    localparam int ITEMS_PER_RUN  = 50;
    localparam int RUNS_PER_PHASE = 4;

    logic              clk;
    logic              rst_n;
    logic              mode_we;
    logic [MODE_W-1:0] mode_wdata;
    int                src_idle_pct;
    int                sink_idle_pct;
    int                mismatches;
    int                outstanding;
    int                composites_checked;
    int                pairs_sent;

    tepb_pix_if pix_if ();
    tepb_res_if res_if ();

    tile_edge_alpha_pixel_blend_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pix_if),
        .composite  (res_if),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata)
    );

    tepb_blend_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .pixels             (pix_if),
        .composite          (res_if),
        .mode_we            (mode_we),
        .mode_wdata         (mode_wdata),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .composites_checked (composites_checked)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic pix_req_t make_pair(input int dy, input int du, input int dv,
                                           input int sy, input int su, input int sv,
                                           input int col, input int row,
                                           input int side);
        pix_req_t req;
        req.dest_luma      = SAMPLE_W'(dy);
        req.dest_cb        = SAMPLE_W'(du);
        req.dest_cr        = SAMPLE_W'(dv);
        req.source_luma    = SAMPLE_W'(sy);
        req.source_cb      = SAMPLE_W'(su);
        req.source_cr      = SAMPLE_W'(sv);
        req.column_in_tile = POS_W'(col);
        req.row_in_tile    = POS_W'(row);
        req.tile_side      = SIDE_W'(side);
        return req;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return '1;
        return SAMPLE_W'($urandom);
    endfunction

    // Positions lean towards both tile edges, where the ramps live.
    function automatic logic [POS_W-1:0] random_position(input logic [SIDE_W-1:0] side);
        int pick;
        int span;
        int pos;
        pick = $urandom_range(99);
        span = (side > TILE_MAX) ? TILE_MAX : side;
        if (pick < 30 || span == 0)
            pos = $urandom_range(2);
        else if (pick < 60)
            pos = span - 1 - $urandom_range(2);
        else if (pick < 90)
            pos = $urandom_range(span - 1);
        else
            pos = $urandom_range(127);
        if (pos < 0)
            pos = 0;
        return POS_W'(pos);
    endfunction

    function automatic pix_req_t random_pair();
        pix_req_t req;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 4)
            req.tile_side = '0;
        else if (pick < 14)
            req.tile_side = SIDE_W'($urandom_range(255, TILE_MAX + 1));
        else
            req.tile_side = SIDE_W'($urandom_range(TILE_MAX, 1));
        req.column_in_tile = random_position(req.tile_side);
        req.row_in_tile    = random_position(req.tile_side);
        req.dest_luma      = random_sample();
        req.dest_cb        = random_sample();
        req.dest_cr        = random_sample();
        req.source_luma    = random_sample();
        req.source_cb      = random_sample();
        req.source_cr      = random_sample();
        return req;
    endfunction

    // Called and returns at a falling edge; valid stays high when the next
    // pair follows without a gap.
    task automatic send_pair(input pix_req_t req);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= req;
        @(posedge clk);
        while (pix_if.ready !== 1'b1)
            @(posedge clk);
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_blend_mode(input logic [MODE_W-1:0] code);
        mode_we    <= 1'b1;
        mode_wdata <= code;
        @(negedge clk);
        mode_we    <= 1'b0;
    endtask

    initial
    begin
        logic [MODE_W-1:0] run_modes[RUNS_PER_PHASE * 3];
        rst_n         = 1'b0;
        mode_we       = 1'b0;
        mode_wdata    = '0;
        pix_if.valid  = 1'b0;
        pix_if.data   = '0;
        res_if.ready  = 1'b0;
        src_idle_pct  = 7;
        sink_idle_pct = 54;
        pairs_sent    = 0;
        run_modes = '{MODE_NORMAL, MODE_ADD, MODE_DIFFERENCE, MODE_MULTIPLY,
                      MODE_LUMA_ONLY, MODE_SPARE_FIRST, MODE_SPARE_LAST, MODE_NORMAL,
                      MODE_LUMA_ONLY, MODE_ADD, MODE_NORMAL, MODE_LUMA_ONLY};
        for (int i = 7; i < RUNS_PER_PHASE * 3; i += 2)
            run_modes[i] = MODE_W'($urandom_range(7));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Normal mode: ramp zones, overlaps, clamped, zero and tiny tiles.
        write_blend_mode(MODE_NORMAL);
        send_pair(make_pair(0, 0, 0, 255, 255, 255, 0, 0, 8));
        send_pair(make_pair(255, 255, 255, 0, 0, 0, 1, 2, 8));
        send_pair(make_pair(200, 16, 240, 50, 128, 128, 7, 6, 8));
        send_pair(make_pair(10, 20, 30, 240, 230, 220, 5, 4, 8));
        send_pair(make_pair(255, 255, 255, 255, 255, 255, 127, 127, 128));
        send_pair(make_pair(0, 0, 0, 255, 255, 255, 64, 64, 255));
        send_pair(make_pair(123, 45, 67, 89, 101, 112, 127, 3, 255));
        send_pair(make_pair(90, 90, 90, 180, 180, 180, 1, 0, 1));
        send_pair(make_pair(77, 88, 99, 11, 22, 33, 0, 50, 0));
        send_pair(make_pair(5, 6, 7, 250, 251, 252, 100, 3, 64));
        send_pair(make_pair(33, 44, 55, 66, 77, 88, 2, 1, 2));
        wait_drained();

        write_blend_mode(MODE_ADD);
        send_pair(make_pair(255, 0, 255, 255, 255, 0, 10, 10, 32));
        send_pair(make_pair(20, 100, 150, 30, 200, 50, 0, 31, 32));
        wait_drained();

        write_blend_mode(MODE_DIFFERENCE);
        send_pair(make_pair(200, 1, 2, 50, 3, 4, 3, 3, 16));
        send_pair(make_pair(50, 250, 251, 200, 9, 8, 15, 0, 16));
        wait_drained();

        write_blend_mode(MODE_MULTIPLY);
        send_pair(make_pair(255, 12, 34, 255, 56, 78, 1, 1, 4));
        send_pair(make_pair(0, 255, 0, 255, 0, 255, 3, 2, 4));
        wait_drained();

        write_blend_mode(MODE_LUMA_ONLY);
        send_pair(make_pair(0, 60, 70, 255, 80, 90, 0, 9, 10));
        send_pair(make_pair(255, 1, 254, 0, 2, 253, 8, 4, 10));
        wait_drained();

        for (int code = MODE_SPARE_FIRST; code <= MODE_SPARE_LAST; code++)
        begin
            write_blend_mode(MODE_W'(code));
            send_pair(make_pair(17, 34, 51, 204, 221, 238, 2, 20, 24));
            wait_drained();
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 7 : (phase == 1) ? 54 : 0;
            sink_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 7 : 0;
            for (int run = 0; run < RUNS_PER_PHASE; run++)
            begin
                write_blend_mode(run_modes[phase * RUNS_PER_PHASE + run]);
                repeat (ITEMS_PER_RUN)
                    send_pair(random_pair());
                wait_drained();
            end
        end

        repeat (16) @(negedge clk);
        $display("Sent %0d pixel pairs and checked %0d composites across all eight",
                 pairs_sent, composites_checked);
        $display("blend codes, three stall patterns and edge, clamped and empty tiles.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
